>>> rtl/ibp_pkg.sv
package ibp_pkg;

	// Frame store geometry and pixel width
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int MAX_BORDER  = 64;
	localparam int PIXEL_BITS  = 16;

	localparam int COL_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_BITS    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	// Field and register widths
	localparam int COORD_BITS  = 9;
	localparam int SIZE_BITS   = 9;
	localparam int BORDER_BITS = 7;
	localparam int MODE_BITS   = 2;
	localparam int FILL_BITS   = 16;
	// signed source-relative coordinate: coordinate minus border, plus mirror headroom
	localparam int S_BITS      = COORD_BITS + 2;

	// Configuration port
	localparam int PADDR_BITS  = 5;
	localparam int PDATA_BITS  = 32;
	localparam int REG_IDX_BITS = PADDR_BITS - 2;

	localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_BORDER_X     = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_BORDER_Y     = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_BORDER_MODE  = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_FILL_VALUE   = 3'd5;

	localparam logic [MODE_BITS-1:0] MODE_FILL      = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_REPLICATE = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_MIRROR    = 2'd2;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Effective configuration, sizes and borders already saturated
	typedef struct packed {
		logic [SIZE_BITS-1:0]   width;
		logic [SIZE_BITS-1:0]   height;
		logic [BORDER_BITS-1:0] bx;
		logic [BORDER_BITS-1:0] by;
		logic [MODE_BITS-1:0]   mode;
		logic [PIXEL_BITS-1:0]  fill;
	} cfg_t;

	// Result of the coordinate map for one transaction
	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic                 wr_en;
		logic                 bord;
		logic                 use_fill;
	} map_t;

endpackage

>>> rtl/ibp_ram.sv
module ibp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> rtl/ibp_regs.sv
module ibp_regs import ibp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [SIZE_BITS-1:0]   width_q;
	logic [SIZE_BITS-1:0]   height_q;
	logic [BORDER_BITS-1:0] bx_q;
	logic [BORDER_BITS-1:0] by_q;
	logic [MODE_BITS-1:0]   mode_q;
	logic [FILL_BITS-1:0]   fill_q;
	logic [REG_IDX_BITS-1:0] idx;
	logic                   wr;

	assign idx    = paddr[PADDR_BITS-1:2];
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_BITS'(MAX_WIDTH);
			height_q <= SIZE_BITS'(MAX_HEIGHT);
			bx_q     <= '0;
			by_q     <= '0;
			mode_q   <= MODE_FILL;
			fill_q   <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_IMAGE_WIDTH:  width_q  <= pwdata[SIZE_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[SIZE_BITS-1:0];
				REG_BORDER_X:     bx_q     <= pwdata[BORDER_BITS-1:0];
				REG_BORDER_Y:     by_q     <= pwdata[BORDER_BITS-1:0];
				REG_BORDER_MODE:  mode_q   <= pwdata[MODE_BITS-1:0];
				REG_FILL_VALUE:   fill_q   <= pwdata[FILL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_IMAGE_WIDTH:  prdata = PDATA_BITS'(width_q);
			REG_IMAGE_HEIGHT: prdata = PDATA_BITS'(height_q);
			REG_BORDER_X:     prdata = PDATA_BITS'(bx_q);
			REG_BORDER_Y:     prdata = PDATA_BITS'(by_q);
			REG_BORDER_MODE:  prdata = PDATA_BITS'(mode_q);
			REG_FILL_VALUE:   prdata = PDATA_BITS'(fill_q);
			default:          prdata = '0;
		endcase
	end

	// Saturate sizes to 1..max and borders to the maximum
	always_comb begin
		if (width_q == '0) begin
			cfg.width = SIZE_BITS'(1);
		end else if (width_q > SIZE_BITS'(MAX_WIDTH)) begin
			cfg.width = SIZE_BITS'(MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		if (height_q == '0) begin
			cfg.height = SIZE_BITS'(1);
		end else if (height_q > SIZE_BITS'(MAX_HEIGHT)) begin
			cfg.height = SIZE_BITS'(MAX_HEIGHT);
		end else begin
			cfg.height = height_q;
		end
		cfg.bx   = (bx_q > BORDER_BITS'(MAX_BORDER)) ? BORDER_BITS'(MAX_BORDER) : bx_q;
		cfg.by   = (by_q > BORDER_BITS'(MAX_BORDER)) ? BORDER_BITS'(MAX_BORDER) : by_q;
		cfg.mode = mode_q;
		cfg.fill = PIXEL_BITS'(fill_q);
	end

endmodule

>>> rtl/ibp_map.sv
module ibp_map import ibp_pkg::*; (
	input  cfg_t                  cfg,
	input  logic                  operation,
	input  logic [COORD_BITS-1:0] column,
	input  logic [COORD_BITS-1:0] row,
	output map_t                  map
);

	// Mirror (when mirror is set), then clamp an out-of-range coordinate onto an axis of length n
	function automatic logic [S_BITS-1:0] map_axis(
		input logic signed [S_BITS-1:0] s,
		input logic [SIZE_BITS-1:0]     n,
		input logic                     mirror
	);
		logic signed [S_BITS-1:0] ns;
		logic signed [S_BITS-1:0] t;
		ns = signed'({{(S_BITS-SIZE_BITS){1'b0}}, n});
		t  = s;
		if (mirror) begin
			if (t[S_BITS-1]) begin
				t = ~t;
			end else if (t >= ns) begin
				t = ns + ns + ~t;
			end
		end
		if (t[S_BITS-1]) begin
			t = '0;
		end else if (t >= ns) begin
			t = ns - signed'(S_BITS'(1));
		end
		return unsigned'(t);
	endfunction

	logic signed [S_BITS-1:0] sx;
	logic signed [S_BITS-1:0] sy;
	logic signed [S_BITS-1:0] w_s;
	logic signed [S_BITS-1:0] h_s;
	logic [S_BITS-1:0]        mx_full;
	logic [S_BITS-1:0]        my_full;
	logic                     mirror;
	logic                     replicate;
	logic                     bord;
	logic                     in_image;
	logic [ADDR_BITS-1:0]     wr_addr;
	logic [ADDR_BITS-1:0]     rd_addr;

	assign w_s = signed'({{(S_BITS-SIZE_BITS){1'b0}}, cfg.width});
	assign h_s = signed'({{(S_BITS-SIZE_BITS){1'b0}}, cfg.height});
	assign sx  = signed'({{(S_BITS-COORD_BITS){1'b0}}, column})
	           - signed'({{(S_BITS-BORDER_BITS){1'b0}}, cfg.bx});
	assign sy  = signed'({{(S_BITS-COORD_BITS){1'b0}}, row})
	           - signed'({{(S_BITS-BORDER_BITS){1'b0}}, cfg.by});

	assign mirror    = (cfg.mode == MODE_MIRROR);
	assign replicate = (cfg.mode == MODE_REPLICATE);
	assign bord      = sx[S_BITS-1] | (sx >= w_s) | sy[S_BITS-1] | (sy >= h_s);

	assign mx_full = map_axis(sx, cfg.width, mirror);
	assign my_full = map_axis(sy, cfg.height, mirror);

	assign in_image = (column < cfg.width) & (row < cfg.height);

	assign wr_addr = ADDR_BITS'(row[ROW_BITS-1:0]) * ADDR_BITS'(MAX_WIDTH)
	               + ADDR_BITS'(column[COL_BITS-1:0]);
	assign rd_addr = ADDR_BITS'(my_full[ROW_BITS-1:0]) * ADDR_BITS'(MAX_WIDTH)
	               + ADDR_BITS'(mx_full[COL_BITS-1:0]);

	always_comb begin
		map.addr     = (operation == OP_STORE) ? wr_addr : rd_addr;
		map.wr_en    = (operation == OP_STORE) & in_image;
		map.bord     = bord;
		map.use_fill = bord & ~(mirror | replicate);
	end

endmodule

>>> rtl/image_border_padder_core.sv
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+---------------------------------
// command   | operation, column, row, pixel_in        | start & !busy, busy is always low
// result    | pixel_out, in_border                    | done, one cycle, no backpressure
// config    | psel penable pwrite paddr pwdata prdata | write when psel&penable&pwrite&pready
//
// One transaction per clock is taken; each result goes through the frame store's
// registered read port and then the output register before done is strobed.
// Reset clears the pipeline valids and the configuration registers; the frame store
// is left as is and holds garbage until written, so no clearing pass is made.
// Results cannot be stalled: done pulses for one cycle and the receiver must take it.
module image_border_padder_core import ibp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  start,
	output logic                  busy,
	input  logic                  operation,
	input  logic [COORD_BITS-1:0] column,
	input  logic [COORD_BITS-1:0] row,
	input  logic [PIXEL_BITS-1:0] pixel_in,
	// result channel
	output logic                  done,
	output logic [PIXEL_BITS-1:0] pixel_out,
	output logic                  in_border,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	cfg_t                  cfg;
	map_t                  map;
	logic                  accept;
	logic [PIXEL_BITS-1:0] ram_rdata;

	// stage 1: frame store access in flight
	logic                  valid_s1;
	logic                  rd_s1;
	logic                  bord_s1;
	logic                  fill_s1;

	// stage 2: result register
	logic                  valid_s2;
	logic [PIXEL_BITS-1:0] pixel_s2;
	logic                  bord_s2;

	// The pipeline never backs up, so the command side is always open.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	ibp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Map the padded coordinate to a frame store address, or take a store address.
	ibp_map u_map (
		.cfg       (cfg),
		.operation (operation),
		.column    (column),
		.row       (row),
		.map       (map)
	);

	// Writes land at the command edge; a read issued the next cycle already sees them.
	ibp_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (STORE_DEPTH)
	) u_frame_store (
		.clk   (clk),
		.we    (accept & map.wr_en),
		.addr  (map.addr),
		.wdata (pixel_in),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// Hold the per-transaction flags alongside the memory read.
	always_ff @(posedge clk) begin
		rd_s1   <= (operation == OP_READ);
		bord_s1 <= map.bord;
		fill_s1 <= map.use_fill;
	end

	// Select fill or stored pixel; drop both to zero for store transactions.
	always_ff @(posedge clk) begin
		priority if (!rd_s1) begin
			pixel_s2 <= '0;
			bord_s2  <= 1'b0;
		end else if (fill_s1) begin
			pixel_s2 <= cfg.fill;
			bord_s2  <= bord_s1;
		end else begin
			pixel_s2 <= ram_rdata;
			bord_s2  <= bord_s1;
		end
	end

	assign done      = valid_s2;
	assign pixel_out = pixel_s2;
	assign in_border = bord_s2;

`ifndef SYNTHESIS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result strobe without a command two cycles earlier");

	a_store_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(operation, 2) == OP_STORE)) |-> (pixel_out == '0 && !in_border))
		else $error("store transaction returned a nonzero result");

	a_fill_in_border: assert property (@(posedge clk) disable iff (!arst_n)
		(done && in_border && cfg.mode != MODE_REPLICATE && cfg.mode != MODE_MIRROR)
		|-> (pixel_out == cfg.fill))
		else $error("constant mode border pixel differs from fill value");
`endif

endmodule
